>>> src/inverse_fitness_roulette_select_macros.svh
// Assertion macros shared by the selector modules.
`ifndef INVERSE_FITNESS_ROULETTE_SELECT_MACROS_SVH
`define INVERSE_FITNESS_ROULETTE_SELECT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define IFRS_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define IFRS_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ifrs_pkg.sv
package ifrs_pkg;

   localparam int MaxPopDefault = 256;
   localparam int FitW = 32;
   localparam int SumW = 40;
   localparam int DivW = 33;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_DRAW  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_STORE, S_MUL, S_SEARCH, S_READ, S_CMP, S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic div_start;
      logic div_step;
      logic store;
      logic mul;
      logic search_init;
      logic mem_read;
      logic compare;
      logic finish;
      logic [1:0] status;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic empty;
      logic full;
      logic search_done;
   } stat_type;

endpackage

>>> src/ifrs_stream_if.sv
interface ifrs_stream_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/ifrs_datapath.sv
module ifrs_datapath #(
   parameter int MAX_POP = ifrs_pkg::MaxPopDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  ifrs_pkg::ctrl_type ctrl,
   output ifrs_pkg::stat_type stat,
   input  logic [31:0]        fitness,
   input  logic [31:0]        random_fraction,
   output logic [7:0]         selected_index,
   output logic [7:0]         fittest_index,
   output logic [8:0]         entry_count,
   output logic [1:0]         status
);
   import ifrs_pkg::*;

   localparam int IdxW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
   localparam int CntW = $clog2(MAX_POP + 1);
   localparam int StepW = $clog2(DivW + 1);
   localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

   logic [SumW-1:0] mem [MAX_POP];
   logic [SumW-1:0] rd_ff;

   logic [CntW-1:0] count_ff, count_in;
   logic [SumW-1:0] total_ff, total_in;
   logic [31:0]     best_w_ff, best_w_in;
   logic [IdxW-1:0] best_p_ff, best_p_in;

   // Operands captured when the request beat is taken.
   logic [31:0]     fit_ff, fit_in;
   logic [31:0]     frac_ff, frac_in;

   // Restoring divider state: 2^32 / fitness.
   logic [DivW-1:0]  quo_ff, quo_in;
   logic [DivW:0]    rem_ff, rem_in;
   logic [DivW-1:0]  num_ff, num_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [DivW:0]    trial;
   logic [31:0]      weight;
   logic [SumW:0]    sum_wide;
   logic [SumW-1:0]  sum_sat;

   // Threshold product registers.
   logic [SumW-1:0] thr_ff, thr_in;
   logic [63:0]     plo_ff, plo_in;
   logic [39:0]     phi_ff, phi_in;
   logic            mulph_ff, mulph_in;

   // Binary search state over entries [lo, hi].
   logic [CntW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CntW:0]   mid_wide;
   logic [CntW-1:0] mid;

   logic [7:0] sel_ff, sel_in;
   logic [1:0] st_ff, st_in;

   assign trial = {rem_ff[DivW-1:0], num_ff[DivW-1]};
   assign weight = quo_ff[DivW-1] ? 32'hFFFF_FFFF : quo_ff[31:0];
   assign sum_wide = {1'b0, total_ff} + {{(SumW-31){1'b0}}, weight};
   assign sum_sat = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
   assign mid_wide = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign mid = mid_wide[CntW-1:0];

   // Next-state logic for the datapath registers other than the weight memory and its read register.
   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      best_w_in = best_w_ff;
      best_p_in = best_p_ff;
      fit_in = fit_ff;
      frac_in = frac_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      step_in = step_ff;
      thr_in = thr_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      mulph_in = mulph_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      sel_in = sel_ff;
      st_in = st_ff;
      if (ctrl.clear) begin
         count_in = '0;
         total_in = '0;
         best_w_in = '0;
         best_p_in = '0;
      end
      if (ctrl.div_start) begin
         fit_in = fitness;
         quo_in = '0;
         rem_in = '0;
         num_in = {1'b1, {(DivW-1){1'b0}}};
         step_in = '0;
      end
      if (ctrl.div_step) begin
         if (trial >= {2'b0, fit_ff}) begin
            rem_in = trial - {2'b0, fit_ff};
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         num_in = {num_ff[DivW-2:0], 1'b0};
         step_in = step_ff + 1'b1;
      end
      if (ctrl.store) begin
         total_in = sum_sat;
         if (weight > best_w_ff) begin
            best_w_in = weight;
            best_p_in = count_ff[IdxW-1:0];
         end
         count_in = count_ff + 1'b1;
      end
      // Low and high partial products first, then their sum.
      if (ctrl.mul) begin
         if (!mulph_ff) begin
            plo_in = 64'(frac_ff) * 64'(total_ff[31:0]);
            phi_in = 40'(frac_ff) * 40'(total_ff[SumW-1:32]);
            mulph_in = 1'b1;
         end else begin
            thr_in = (phi_ff << 0) + {8'b0, plo_ff[63:32]};
            mulph_in = 1'b0;
         end
      end
      if (ctrl.search_init) begin
         frac_in = random_fraction;
         lo_in = '0;
         hi_in = count_ff - 1'b1;
      end
      if (ctrl.compare) begin
         if (rd_ff >= thr_ff) hi_in = mid;
         else lo_in = mid + 1'b1;
      end
      if (ctrl.finish) begin
         st_in = ctrl.status;
         sel_in = 8'd0;
      end
      if (ctrl.search_init) sel_in = 8'd0;
      if (ctrl.compare && (lo_in == hi_in)) sel_in = 8'(lo_in);
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         best_w_ff <= '0;
         best_p_ff <= '0;
         mulph_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         best_w_ff <= best_w_in;
         best_p_ff <= best_p_in;
         mulph_ff <= mulph_in;
         step_ff <= step_in;
      end
      fit_ff <= fit_in;
      frac_ff <= frac_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      thr_ff <= thr_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      sel_ff <= sel_in;
      st_ff <= st_in;
   end

   // Cumulative weight memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.store) mem[count_ff[IdxW-1:0]] <= sum_sat;
      if (ctrl.mem_read) rd_ff <= mem[mid[IdxW-1:0]];
   end

   assign stat.div_done = (step_ff == StepW'(DivW));
   assign stat.empty = (count_ff == '0);
   assign stat.full = (count_ff >= CntW'(MAX_POP));
   assign stat.search_done = (lo_ff == hi_ff);

   assign selected_index = sel_ff;
   assign fittest_index = 8'(best_p_ff);
   assign entry_count = 9'(count_ff);
   assign status = st_ff;

`include "inverse_fitness_roulette_select_macros.svh"
   `IFRS_ASSERT_NEXT(a_store_counts, clock, reset, ctrl.store && !stat.full,
      count_ff == $past(count_ff) + 1'b1, "store did not advance the count")
   `IFRS_ASSERT_IMPL(a_search_bounds, clock, reset, ctrl.compare, lo_ff <= hi_ff,
      "search bounds crossed")
   `IFRS_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CntW'(MAX_POP),
      "count beyond capacity")
endmodule

>>> src/ifrs_controller.sv
module ifrs_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         command,
   input  logic [31:0]        fitness,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ifrs_pkg::ctrl_type ctrl,
   input  ifrs_pkg::stat_type stat
);
   import ifrs_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] cmd_ff;
   logic       busy_ff, busy_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (command == CMD_LOAD && fitness != '0 && !stat.full)
                  state_in = S_DIV;
               else if (command == CMD_DRAW && !stat.empty) state_in = S_MUL;
               else state_in = S_RESP;
            end
         end
         S_DIV:    if (stat.div_done) state_in = S_STORE;
         S_STORE:  state_in = S_RESP;
         S_MUL:    state_in = busy_ff ? S_SEARCH : S_MUL;
         S_SEARCH: state_in = stat.search_done ? S_RESP : S_READ;
         S_READ:   state_in = S_CMP;
         S_CMP:    state_in = S_SEARCH;
         S_RESP:   if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   assign busy_in = (state_ff == S_MUL) ? !busy_ff : 1'b0;

   // Outputs.
   always_comb begin
      ctrl = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.finish = 1'b1;
               ctrl.status = ST_OK;
               if (command == CMD_CLEAR) ctrl.clear = 1'b1;
               else if (command == CMD_LOAD) begin
                  if (fitness == '0) ctrl.status = ST_ZERO;
                  else if (stat.full) ctrl.status = ST_FULL;
                  else ctrl.div_start = 1'b1;
               end else if (command == CMD_DRAW) begin
                  if (stat.empty) ctrl.status = ST_EMPTY;
                  else ctrl.search_init = 1'b1;
               end
            end
         end
         S_DIV:    ctrl.div_step = !stat.div_done;
         S_STORE:  ctrl.store = 1'b1;
         S_MUL:    ctrl.mul = 1'b1;
         S_SEARCH: ctrl.mem_read = 1'b1;
         S_READ:   ctrl.mem_read = 1'b0;
         S_CMP:    ctrl.compare = 1'b1;
         S_RESP:   rsp_valid = 1'b1;
         default:  ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
      end
      if (req_valid && req_ready) cmd_ff <= command;
   end

`include "inverse_fitness_roulette_select_macros.svh"
   `IFRS_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, !rsp_valid,
      "input taken while a beat is pending")
   `IFRS_ASSERT_NEXT(a_resp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "result beat dropped")
   `IFRS_ASSERT_IMPL(a_draw_path, clock, reset, state_ff == S_CMP, cmd_ff == CMD_DRAW,
      "search outside a draw")
endmodule

>>> src/inverse_fitness_roulette_select.sv
// Channel | Direction | Beat contents
// req     | in        | command, fitness, random_fraction
// rsp     | out       | selected_index, fittest_index, entry_count, status
// Load: accept, a pass through the bit-serial divider, a store, then response.
// Draw: multiply, then search, read and compare per binary-search step, then a
// final search. Operands are captured when the request beat is taken.
// Clear and rejected items go to the response. One item is in flight at a time.
// Reset is synchronous and active high; the memory needs no clearing.
// A stalled response holds the block; no new beat is taken until it leaves.
module inverse_fitness_roulette_select #(
   parameter int MAX_POP = ifrs_pkg::MaxPopDefault
) (
   input logic clock,
   input logic reset,
   ifrs_stream_if.sink   req,
   ifrs_stream_if.source rsp
);
   import ifrs_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   ifrs_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .command(req.data[65:64]), .fitness(req.data[63:32]),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .ctrl(ctrl), .stat(stat)
   );

   ifrs_datapath #(.MAX_POP(MAX_POP)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .fitness(req.data[63:32]), .random_fraction(req.data[31:0]),
      .selected_index(rsp.data[26:19]), .fittest_index(rsp.data[18:11]),
      .entry_count(rsp.data[10:2]), .status(rsp.data[1:0])
   );
endmodule
